// File: hdl/eci_pkg.sv
// Shared constants, types and tables of the easing curve interpolator.
// Depends on nothing; eci_front, eci_iter, eci_back and the top level import it.
package eci_pkg;

  localparam int FB           = 16;            // fraction bits of values, times and weights
  localparam int ONE_W        = FB + 1;        // width of a weight in [0, ONE]
  localparam int DEN_W        = ONE_W + 1;     // width of the ease-in-out divisor
  localparam int NUM_W        = 2 * FB + 2;    // width of the ease-in-out dividend
  localparam int XW           = 33;            // CORDIC datapath width, Q2.30 plus margin
  localparam int CORDIC_STEPS = 28;
  localparam int DIV_STEPS    = FB + 1;
  localparam int ZP_W         = ONE_W + 31;    // phase times half pi
  localparam int PW           = XW + ONE_W + 1;

  localparam logic [ONE_W-1:0] ONE      = ONE_W'(1) << FB;
  localparam logic [ONE_W-1:0] HALF_ONE = ONE_W'(1) << (FB - 1);
  localparam logic [30:0]      HALF_PI  = 31'd1686629713;
  localparam logic signed [XW-1:0] GAIN   = 33'sd652032874;
  localparam logic signed [XW-1:0] Q30_ONE = 33'sd1073741824;

  // Curve codes.
  localparam logic [2:0] CURVE_LINEAR    = 3'd0;
  localparam logic [2:0] CURVE_EASE_IN   = 3'd1;
  localparam logic [2:0] CURVE_EASE_OUT  = 3'd2;
  localparam logic [2:0] CURVE_EASE_IO   = 3'd3;
  localparam logic [2:0] CURVE_BOOMERANG = 3'd4;

  // One request on its way through the rotation and division stages.
  typedef struct packed {
    logic                    valid;
    logic                    bad;
    logic [2:0]              curve;
    logic signed [31:0]      start_value;
    logic signed [31:0]      end_value;
    logic [ONE_W-1:0]        t;
    logic [ONE_W-1:0]        a;
    logic signed [XW-1:0]    x;
    logic signed [XW-1:0]    y;
    logic signed [XW-1:0]    z;
    logic [NUM_W-1:0]        num;
    logic [DEN_W-1:0]        den;
    logic [DEN_W-1:0]        rem;
    logic [ONE_W-1:0]        quo;
  } pipe_t;

  // Arctangent of 2^-i in Q2.30.
  function automatic logic signed [XW-1:0] atan_q30(input int i);
    logic signed [XW-1:0] v;
    begin
      unique case (i)
        0:  v = 33'sh03243F6A8;
        1:  v = 33'sh01DAC6705;
        2:  v = 33'sh00FADBAFC;
        3:  v = 33'sh007F56EA6;
        4:  v = 33'sh003FEAB76;
        5:  v = 33'sh001FFD55B;
        6:  v = 33'sh000FFFAAA;
        7:  v = 33'sh0007FFF55;
        8:  v = 33'sh0003FFFEA;
        9:  v = 33'sh0001FFFFD;
        10: v = 33'sh0000FFFFF;
        11: v = 33'sh00007FFFF;
        12: v = 33'sh00003FFFF;
        13: v = 33'sh00001FFFF;
        14: v = 33'sh00000FFFF;
        15: v = 33'sh000007FFF;
        16: v = 33'sh000003FFF;
        17: v = 33'sh000001FFF;
        18: v = 33'sh000000FFF;
        19: v = 33'sh0000007FF;
        20: v = 33'sh0000003FF;
        21: v = 33'sh0000001FF;
        22: v = 33'sh0000000FF;
        23: v = 33'sh00000007F;
        24: v = 33'sh00000003F;
        25: v = 33'sh00000001F;
        26: v = 33'sh00000000F;
        27: v = 33'sh000000008;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

// File: hdl/eci_in_if.sv
// Request channel of the easing curve interpolator.
// Depends on nothing.
interface eci_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         curve;
  logic signed [31:0] start_value;
  logic signed [31:0] end_value;
  logic signed [31:0] time_value;

  modport source (output valid, curve, start_value, end_value, time_value, input ready);
  modport sink   (input valid, curve, start_value, end_value, time_value, output ready);
endinterface

// File: hdl/eci_out_if.sv
// Result channel of the easing curve interpolator.
// Depends on nothing.
interface eci_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result;
  logic               bad_curve;

  modport source (output valid, result, bad_curve, input ready);
  modport sink   (input valid, result, bad_curve, output ready);
endinterface

// File: hdl/eci_front.sv
// Front stages: time clamp, phase selection, squares and angle scaling.
// Depends on eci_pkg.
module eci_front
  import eci_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [2:0]         curve,
  input  logic signed [31:0] start_value,
  input  logic signed [31:0] end_value,
  input  logic signed [31:0] time_value,
  output pipe_t              head
);

  localparam logic signed [31:0] ONE_S = 32'(ONE);

  logic [ONE_W-1:0] t_c, u_c;

  // Stage one registers.
  logic               v1, bad1;
  logic [2:0]         curve1;
  logic signed [31:0] s1, e1;
  logic [ONE_W-1:0]   t1, u1;

  // Stage two registers.
  logic               v2, bad2;
  logic [2:0]         curve2;
  logic signed [31:0] s2, e2;
  logic [ONE_W-1:0]   t2;
  logic [2*ONE_W-1:0] sqa2, sqb2;
  logic [ZP_W-1:0]    zp2;

  logic [2*ONE_W-1:0] sqa_r, sqb_r;
  logic [ONE_W-1:0]   a_c, b_c;
  logic [DEN_W-1:0]   den_c;
  logic [NUM_W-1:0]   num_c;
  logic [ZP_W-1:0]    zp_r;

  // Clamp time to [0, ONE] and fold the boomerang phase.
  always_comb begin
    if (time_value < 32'sd0) begin
      t_c = '0;
    end else if (time_value > ONE_S) begin
      t_c = ONE;
    end else begin
      t_c = time_value[ONE_W-1:0];
    end
    if (curve == CURVE_BOOMERANG) begin
      if (t_c <= HALF_ONE) begin
        u_c = t_c << 1;
      end else begin
        u_c = (ONE - t_c) << 1;
      end
    end else begin
      u_c = t_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bad1   <= (curve > CURVE_BOOMERANG);
      curve1 <= curve;
      s1     <= start_value;
      e1     <= end_value;
      t1     <= t_c;
      u1     <= u_c;
    end
  end

  // Squares for ease-in and ease-in-out, and the phase scaled to radians.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bad2   <= bad1;
      curve2 <= curve1;
      s2     <= s1;
      e2     <= e1;
      t2     <= t1;
      sqa2   <= t1 * t1;
      sqb2   <= (ONE - t1) * (ONE - t1);
      zp2    <= ZP_W'(u1) * ZP_W'(HALF_PI);
    end
  end

  // Round the products and set up the divider and the rotation.
  always_comb begin
    sqa_r = sqa2 + (2*ONE_W)'(HALF_ONE);
    sqb_r = sqb2 + (2*ONE_W)'(HALF_ONE);
    a_c   = sqa_r[FB+ONE_W-1:FB];
    b_c   = sqb_r[FB+ONE_W-1:FB];
    den_c = DEN_W'(a_c) + DEN_W'(b_c);
    num_c = (NUM_W'(a_c) << FB) + NUM_W'(den_c >> 1);
    zp_r  = zp2 + ZP_W'(HALF_ONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else if (adv) begin
      head.valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      head.bad         <= bad2;
      head.curve       <= curve2;
      head.start_value <= s2;
      head.end_value   <= e2;
      head.t           <= t2;
      head.a           <= a_c;
      head.x           <= GAIN;
      head.y           <= '0;
      head.z           <= $signed({1'b0, zp_r[ZP_W-1:FB]});
      head.num         <= num_c;
      head.den         <= den_c;
      head.rem         <= DEN_W'(num_c[NUM_W-1:FB+1]);
      head.quo         <= '0;
    end
  end

endmodule

// File: hdl/eci_iter.sv
// Rotation and division chain: one CORDIC step in each register stage and
// one restoring division step in the first DIV_STEPS. Depends on eci_pkg.
module eci_iter
  import eci_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  pipe_t head,
  output pipe_t tail
);

  pipe_t stg [CORDIC_STEPS+1];

  assign stg[0] = head;
  assign tail   = stg[CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    pipe_t nxt;
    logic [DEN_W:0] trial;

    // Rotate towards zero residual angle; in the first DIV_STEPS stages, also divide one quotient bit.
    always_comb begin
      nxt   = stg[i];
      trial = '0;
      if (stg[i].z >= 0) begin
        nxt.x = stg[i].x - (stg[i].y >>> i);
        nxt.y = stg[i].y + (stg[i].x >>> i);
        nxt.z = stg[i].z - atan_q30(i);
      end else begin
        nxt.x = stg[i].x + (stg[i].y >>> i);
        nxt.y = stg[i].y - (stg[i].x >>> i);
        nxt.z = stg[i].z + atan_q30(i);
      end
      if (i < DIV_STEPS) begin
        trial = {stg[i].rem, stg[i].num[(i < DIV_STEPS) ? (FB - i) : 0]};
        if (trial >= {1'b0, stg[i].den}) begin
          trial   = trial - {1'b0, stg[i].den};
          nxt.quo = {stg[i].quo[ONE_W-2:0], 1'b1};
        end else begin
          nxt.quo = {stg[i].quo[ONE_W-2:0], 1'b0};
        end
        nxt.rem = trial[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[i+1].valid <= 1'b0;
      end else if (adv) begin
        stg[i+1].valid <= nxt.valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg[i+1].bad         <= nxt.bad;
        stg[i+1].curve       <= nxt.curve;
        stg[i+1].start_value <= nxt.start_value;
        stg[i+1].end_value   <= nxt.end_value;
        stg[i+1].t           <= nxt.t;
        stg[i+1].a           <= nxt.a;
        stg[i+1].x           <= nxt.x;
        stg[i+1].y           <= nxt.y;
        stg[i+1].z           <= nxt.z;
        stg[i+1].num         <= nxt.num;
        stg[i+1].den         <= nxt.den;
        stg[i+1].rem         <= nxt.rem;
        stg[i+1].quo         <= nxt.quo;
      end
    end
  end

endmodule

// File: hdl/eci_back.sv
// Back stages: weight selection, scaling of the span and the output register.
// Depends on eci_pkg.
module eci_back
  import eci_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  pipe_t              tail,
  output logic               out_valid,
  output logic signed [31:0] result,
  output logic               bad_curve
);

  logic signed [XW-1:0] y_c;
  logic [31:0]          ysum;
  logic [ONE_W-1:0]     sin_c, f_c;

  logic               v1, bad1;
  logic signed [31:0] s1;
  logic signed [32:0] d1;
  logic [ONE_W-1:0]   f1;

  logic               v2, bad2;
  logic signed [31:0] s2;
  logic signed [PW-1:0] p2, psum;

  // Round the sine to a weight and pick the curve's weight.
  always_comb begin
    if (tail.y < 0) begin
      y_c = '0;
    end else if (tail.y > Q30_ONE) begin
      y_c = Q30_ONE;
    end else begin
      y_c = tail.y;
    end
    ysum = 32'(y_c[30:0]) + (32'd1 << (29 - FB));
    sin_c = ysum[30:30-FB];
    if (sin_c > ONE) begin
      sin_c = ONE;
    end
    unique case (tail.curve)
      CURVE_LINEAR:   f_c = tail.t;
      CURVE_EASE_IN:  f_c = tail.a;
      CURVE_EASE_IO:  f_c = tail.quo;
      default:        f_c = sin_c;
    endcase
    if (f_c > ONE) begin
      f_c = ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= tail.valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  // Span, multiply, then round and offset by the start value.
  always_ff @(posedge clk) begin
    if (adv) begin
      bad1 <= tail.bad;
      s1   <= tail.start_value;
      d1   <= 33'(tail.end_value) - 33'(tail.start_value);
      f1   <= f_c;
      bad2 <= bad1;
      s2   <= s1;
      p2   <= PW'(d1) * PW'($signed({1'b0, f1}));
    end
  end

  assign psum = p2 + PW'($signed({1'b0, HALF_ONE}));

  always_ff @(posedge clk) begin
    if (adv) begin
      bad_curve <= bad2;
      result    <= bad2 ? 32'sd0 : s2 + $signed(psum[FB+31:FB]);
    end
  end

endmodule

// File: hdl/easing_curve_interpolator_core.sv
// Easing curve interpolator, top level.
// Requests arrive on the request channel (curve code, start, end and time,
// all signed Q16.16); results leave on the response channel.
// Each request yields one result: start + (end - start) * f(t), with t
// clamped to [0, 1]. Unknown curve codes give zero and raise bad_curve.
// The datapath is a single pipeline of 34 register stages: three front
// stages (clamp, squares, rounding), 28 stages that each hold one CORDIC
// rotation (the first DIV_STEPS of them also one restoring division
// step), and three back stages (weight select, multiply, round and add
// into the output register). Throughput is one request per cycle unless
// the receiver stalls; the CORDIC chain sets the depth.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and ready drops; nothing is lost or repeated. Synchronous reset clears
// all valid bits, so no result is shown after reset until one is computed.
// Depends on eci_pkg, eci_in_if, eci_out_if, eci_front, eci_iter, eci_back.
module easing_curve_interpolator_core
  import eci_pkg::*;
(
  input logic       clk,
  input logic       rst,
  eci_in_if.sink    request,
  eci_out_if.source response
);

  logic  adv;
  pipe_t head, tail;

  // The pipeline moves whenever the output register is free or being read.
  assign adv           = !response.valid || response.ready;
  assign request.ready = adv;

  eci_front u_front (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (request.valid),
    .curve       (request.curve),
    .start_value (request.start_value),
    .end_value   (request.end_value),
    .time_value  (request.time_value),
    .head        (head)
  );

  eci_iter u_iter (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .head (head),
    .tail (tail)
  );

  eci_back u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .tail      (tail),
    .out_valid (response.valid),
    .result    (response.result),
    .bad_curve (response.bad_curve)
  );

  // A bad curve always reports zero.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    response.valid && response.bad_curve |-> response.result == 32'sd0)
    else $error("bad curve with nonzero result");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    response.valid && !response.ready |=> response.valid && $stable(response.result))
    else $error("stalled result changed");

  // No request is taken while a result waits unread.
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    response.valid && !response.ready |-> !request.ready)
    else $error("request taken during stall");

endmodule
